FILE: hw/rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg: shared types and constants for the circular FIFO queue
// Request and status codes, field widths and the control bundle that the
// top level hands to the row of storage cells.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int WORD_W  = 32;  // width of data fields on the ports
  localparam int CNT_W   = 5;   // item count / capacity width
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_CLR = 2'd2,
    REQ_NOP = 2'd3
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic             enq;    // load the incoming word into cell [count]
    logic             deq;    // every cell takes its right neighbor's word; the last keeps its own
    logic [CNT_W-1:0] count;  // items held before this transaction
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/cfq_intf.sv
// ----------------------------------------------------------------------------
// cfq_intf: valid/ready channels of the circular FIFO queue
// Request channel, result channel and capacity write channel.
// ----------------------------------------------------------------------------
interface cfq_req_if;
  logic                         valid;
  logic                         ready;
  logic [cfq_pkg::REQ_W-1:0]    req_type;
  logic [cfq_pkg::WORD_W-1:0]   data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface cfq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cfq_pkg::WORD_W-1:0]   data_out;
  logic [cfq_pkg::STAT_W-1:0]   status;
  logic [cfq_pkg::CNT_W-1:0]    item_total;
  logic [cfq_pkg::WORD_W-1:0]   oldest_value;
  logic [cfq_pkg::WORD_W-1:0]   newest_value;
  logic                         is_empty;
  logic                         is_full;

  modport source (output valid, output data_out, output status, output item_total,
                  output oldest_value, output newest_value, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input data_out, input status, input item_total,
                  input oldest_value, input newest_value, input is_empty,
                  input is_full, output ready);
endinterface

interface cfq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cfq_pkg::CNT_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cfq_cell.sv
// ----------------------------------------------------------------------------
// cfq_cell: one storage cell of the queue row
// Holds one word. Loads the incoming word when it is the first free slot,
// or takes its right neighbor's word when the row shifts toward the head.
// ----------------------------------------------------------------------------
module cfq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                    clk,
  input  cfq_pkg::cell_ctrl_t     ctrl,
  input  logic [DATA_WIDTH-1:0]   word_in,
  input  logic [DATA_WIDTH-1:0]   right_in,
  output logic [DATA_WIDTH-1:0]   data_o
);
  import cfq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.enq && (int'(ctrl.count) == IDX)) begin
      data_nxt = word_in;
    end else if (ctrl.deq) begin
      data_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

FILE: hw/rtl/cfq_row.sv
// ----------------------------------------------------------------------------
// cfq_row: row of storage cells, oldest item in cell 0
// Items sit packed from cell 0 upward; a dequeue shifts the whole row one
// cell toward the head.
// ----------------------------------------------------------------------------
module cfq_row #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  cfq_pkg::cell_ctrl_t     ctrl,
  input  logic [DATA_WIDTH-1:0]   word_in,
  output logic [DATA_WIDTH-1:0]   head_o,   // cell 0
  output logic [DATA_WIDTH-1:0]   next_o    // cell 1
);
  import cfq_pkg::*;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] right;
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    cfq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .word_in  (word_in),
      .right_in (right),
      .data_o   (cell_data[i])
    );
  end

  assign head_o = cell_data[0];
  assign next_o = cell_data[1];

endmodule

FILE: hw/rtl/circular_fifo_queue_unit.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue_unit: first-in first-out queue with request channel
// Enqueue, dequeue and clear requests; one result per request with status,
// count, head and tail words and empty/full flags. Capacity is set through
// the configuration write channel.
// ----------------------------------------------------------------------------
// One request transaction per clock: the result is registered and appears
// on out_rsp the cycle after the request is taken, and a new request is
// taken in that same cycle as long as the result register is free or being
// drained. The figure is set by the single update of the cell row and the
// item counter per transaction. Storage is a row of DEPTH cells with the
// oldest word in cell 0; a dequeue shifts the row by one cell. No clearing
// pass follows reset. A capacity of 0 acts as 1 and one above DEPTH acts as
// DEPTH; any capacity write empties the queue.
module circular_fifo_queue_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  cfq_req_if.sink   in_req,
  cfq_rsp_if.source out_rsp,
  cfq_cfg_if.sink   cfg_wr
);
  import cfq_pkg::*;

  logic [CNT_W-1:0]      cap_r, cap_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] newest_r, newest_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [WORD_W-1:0]     res_data_r, res_data_nxt;
  status_t               res_stat_r, res_stat_nxt;
  logic [WORD_W-1:0]     res_old_r, res_old_nxt;
  logic [WORD_W-1:0]     res_new_r, res_new_nxt;
  logic                  res_full_r, res_full_nxt;

  logic [CNT_W-1:0]      cap_eff;
  logic                  acc;
  req_kind_t             kind;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] head_w, next_w, oldest_w;
  cell_ctrl_t            ctrl;

  assign kind = req_kind_t'(in_req.req_type);
  assign word = DATA_WIDTH'(in_req.data_in);

  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_r) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end
  end

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign cfg_wr.ready = 1'b1;
  assign acc          = in_req.valid && in_req.ready;

  assign ctrl.enq   = acc && (kind == REQ_ENQ) && (count_r < cap_eff);
  assign ctrl.deq   = acc && (kind == REQ_DEQ) && (count_r != '0);
  assign ctrl.count = count_r;

  cfq_row #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_row (
    .clk     (clk),
    .ctrl    (ctrl),
    .word_in (word),
    .head_o  (head_w),
    .next_o  (next_w)
  );

  // Head word as it stands after this transaction.
  always_comb begin
    oldest_w = head_w;
    if (ctrl.enq && (count_r == '0)) begin
      oldest_w = word;
    end else if (ctrl.deq) begin
      oldest_w = next_w;
    end
  end

  // Queue state update
  always_comb begin
    cap_nxt    = cap_r;
    count_nxt  = count_r;
    newest_nxt = newest_r;
    if (cfg_wr.valid) begin
      cap_nxt   = cfg_wr.data;
      count_nxt = '0;
    end else if (acc) begin
      if (ctrl.enq) begin
        count_nxt  = count_r + CNT_W'(1);
        newest_nxt = word;
      end else if (ctrl.deq) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (kind == REQ_CLR) begin
        count_nxt = '0;
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_data_nxt  = res_data_r;
    res_stat_nxt  = res_stat_r;
    res_old_nxt   = res_old_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (acc) begin
      out_valid_nxt = 1'b1;
      res_data_nxt  = ctrl.deq ? WORD_W'(head_w) : '0;
      res_stat_nxt  = ST_DONE;
      if ((kind == REQ_ENQ) && !ctrl.enq) begin
        res_stat_nxt = ST_FULL;
      end else if ((kind == REQ_DEQ) && !ctrl.deq) begin
        res_stat_nxt = ST_EMPTY;
      end
      res_old_nxt  = (count_nxt != '0) ? WORD_W'(oldest_w) : '0;
      res_new_nxt  = (count_nxt != '0) ? WORD_W'(newest_nxt) : '0;
      res_full_nxt = (count_nxt == cap_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  assign res_cnt_nxt = acc ? count_nxt : res_cnt_r;

  always_ff @(posedge clk) begin
    newest_r   <= newest_nxt;
    res_data_r <= res_data_nxt;
    res_stat_r <= res_stat_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_old_r  <= res_old_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.data_out     = res_data_r;
  assign out_rsp.status       = res_stat_r;
  assign out_rsp.item_total   = res_cnt_r;
  assign out_rsp.oldest_value = res_old_r;
  assign out_rsp.newest_value = res_new_r;
  assign out_rsp.is_empty     = (res_cnt_r == '0);
  assign out_rsp.is_full      = res_full_r;

endmodule
